>>> sv/pulse_train_bit_decoder_assert.svh
// Assertion macros shared by the decoder modules.
// Each macro expands to a concurrent assertion in simulation and to nothing
// in synthesis.
`ifndef PULSE_TRAIN_BIT_DECODER_ASSERT_SVH
`define PULSE_TRAIN_BIT_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
// General property, checked on every clock edge outside reset
`define PTBD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Same-cycle implication from a condition to a consequence
`define PTBD_ASSERT_IMPL(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);
`else
`define PTBD_ASSERT(label, clk, rst_n, prop, msg)
`define PTBD_ASSERT_IMPL(label, clk, rst_n, cond, conseq, msg)
`endif
`endif

>>> sv/ptbd_pkg.sv
package ptbd_pkg;

    // Default store capacity in bytes
    localparam int MAX_BYTES_DEF = 32;

    // Field widths
    localparam int CNT_W     = 10;
    localparam int BYTE_W    = 8;
    localparam int LEN_OUT_W = 6;
    localparam int BIT_IDX_W = 4;
    localparam int CFG_IDX_W = 2;

    // Data bits per word, parity bit follows
    localparam logic [BIT_IDX_W-1:0] WORD_BITS = 4'd8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MIN = 2'd1;

    // Configuration reset values
    localparam logic [CNT_W-1:0] RST_MIN_PULSE = 10'd5;
    localparam logic [CNT_W-1:0] RST_START_MIN = 10'd45;

    // Divide by five as multiply by 3277 / 2**14, exact for values below 2048
    localparam int          DIV5_PROD_W = 23;
    localparam logic [11:0] DIV5_MUL    = 12'd3277;
    localparam int          DIV5_SHIFT  = 14;

    // Command queue depth between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        BK_IDLE,
        BK_DRAIN
    } t_back_state;

    // Odd parity bit of a data byte
    function automatic logic odd_parity(input logic [BYTE_W-1:0] v);
        return ~(^v);
    endfunction

endpackage

>>> sv/pulse_train_bit_decoder.sv
// Pulse train bit decoder. Each input transaction reports either the end of
// one carrier pulse train (mode 0, with its pulse count) or a stream timeout
// (mode 1). Bit events are accepted back to back; the decoder keeps one word
// in flight and writes each completed byte into a MAX_BYTES-entry store. A
// stream end queues a drain command, and the back end then reads the store
// through its single read port and delivers one result per cycle while the
// output is not stalled, passing each byte through a read stage and an
// output register. While a drain command is queued or still has reads to
// issue, a bit event that would complete a word is held, and a stream end is
// held while the two-entry command queue is full. The store needs no
// clearing after reset; only bytes of the current message are ever read.
// Configuration writes are always taken.
module pulse_train_bit_decoder #(
    parameter int MAX_BYTES = ptbd_pkg::MAX_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ptbd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ptbd_pkg::CNT_W-1:0]     i_cfg_data,
    // event input
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_mode,
    input  logic [ptbd_pkg::CNT_W-1:0]     i_pulse_count,
    // result output
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [ptbd_pkg::BYTE_W-1:0]    o_byte_value,
    output logic                           o_last_byte,
    output logic [ptbd_pkg::LEN_OUT_W-1:0] o_message_length,
    output logic                           o_parity_ok
);

    localparam int IDX_W = $clog2(MAX_BYTES);
    localparam int LEN_W = $clog2(MAX_BYTES + 1);

    logic                        back_busy;
    logic                        q_full;
    logic                        q_push;
    logic [LEN_W:0]              q_wdata;
    logic                        q_valid;
    logic                        q_pop;
    logic [LEN_W:0]              q_rdata;
    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    logic [ptbd_pkg::BYTE_W-1:0] wr_data;
    logic                        rd_en;
    logic [IDX_W-1:0]            rd_addr;
    logic [ptbd_pkg::BYTE_W-1:0] rd_data;

    assign o_cfg_ready = 1'b1;

    ptbd_front #(
        .MAX_BYTES (MAX_BYTES),
        .IDX_W     (IDX_W),
        .LEN_W     (LEN_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_pulse_count (i_pulse_count),
        .i_back_busy   (back_busy),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_data      (q_wdata),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data)
    );

    ptbd_queue #(
        .WIDTH (LEN_W + 1)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_rdata)
    );

    ptbd_ram #(
        .WIDTH (ptbd_pkg::BYTE_W),
        .DEPTH (MAX_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    ptbd_back #(
        .MAX_BYTES (MAX_BYTES),
        .IDX_W     (IDX_W),
        .LEN_W     (LEN_W)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_data         (q_rdata),
        .o_q_pop          (q_pop),
        .o_busy           (back_busy),
        .o_rd_en          (rd_en),
        .o_rd_addr        (rd_addr),
        .i_rd_data        (rd_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_byte_value     (o_byte_value),
        .o_last_byte      (o_last_byte),
        .o_message_length (o_message_length),
        .o_parity_ok      (o_parity_ok)
    );

endmodule

>>> sv/ptbd_ram.sv
module ptbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/ptbd_queue.sv
module ptbd_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = ptbd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Hold queued commands
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> sv/ptbd_front.sv
`include "pulse_train_bit_decoder_assert.svh"

module ptbd_front #(
    parameter int MAX_BYTES = ptbd_pkg::MAX_BYTES_DEF,
    parameter int IDX_W     = $clog2(MAX_BYTES),
    parameter int LEN_W     = $clog2(MAX_BYTES + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_valid,
    input  logic [ptbd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ptbd_pkg::CNT_W-1:0]     i_cfg_data,
    // event input
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_mode,
    input  logic [ptbd_pkg::CNT_W-1:0]     i_pulse_count,
    // drain command queue
    input  logic                           i_back_busy,
    input  logic                           i_q_full,
    output logic                           o_q_push,
    output logic [LEN_W:0]                 o_q_data,
    // byte store write
    output logic                           o_wr_en,
    output logic [IDX_W-1:0]               o_wr_addr,
    output logic [ptbd_pkg::BYTE_W-1:0]    o_wr_data
);

    logic [ptbd_pkg::CNT_W-1:0]     r_min_pulse;
    logic [ptbd_pkg::CNT_W-1:0]     r_start_min;
    logic [ptbd_pkg::BIT_IDX_W-1:0] r_bit_idx;
    logic [ptbd_pkg::BIT_IDX_W-1:0] n_bit_idx;
    logic [LEN_W-1:0]               r_byte_idx;
    logic [LEN_W-1:0]               n_byte_idx;
    logic                           r_awaiting;
    logic                           n_awaiting;
    logic [ptbd_pkg::CNT_W-1:0]     r_thresh;
    logic [ptbd_pkg::CNT_W-1:0]     n_thresh;
    logic                           r_good;
    logic                           n_good;
    logic [ptbd_pkg::BYTE_W-1:0]    r_byte;
    logic [ptbd_pkg::BYTE_W-1:0]    n_byte;

    logic [LEN_W-1:0]                   eff_idx;
    logic                               pass;
    logic                               is_bit;
    logic                               parity_step;
    logic                               acc;
    logic                               bit_val;
    logic [ptbd_pkg::DIV5_PROD_W-1:0]   thr_prod;

    // Wrap the word index once the store is full
    assign eff_idx = (r_byte_idx >= LEN_W'(MAX_BYTES)) ? '0 : r_byte_idx;

    // Classify the event
    assign pass = (i_pulse_count >= r_min_pulse)
               && !(r_awaiting && (i_pulse_count < r_start_min));
    assign is_bit      = !i_mode && pass && !r_awaiting;
    assign parity_step = is_bit && (r_bit_idx == ptbd_pkg::WORD_BITS);
    assign bit_val     = (i_pulse_count < r_thresh);

    // Hold a word completion while the back end has a drain queued or still
    // reads the store, and a stream end while the queue is full
    assign o_in_stall = (parity_step && i_back_busy) || (i_mode && i_q_full);
    assign acc        = i_in_valid && !o_in_stall;

    // Threshold of two fifths of the start bit count
    assign thr_prod = ptbd_pkg::DIV5_PROD_W'({i_pulse_count, 1'b0})
                    * ptbd_pkg::DIV5_PROD_W'(ptbd_pkg::DIV5_MUL);

    // Store write and drain command
    assign o_wr_en   = acc && parity_step;
    assign o_wr_addr = eff_idx[IDX_W-1:0];
    assign o_wr_data = r_byte;
    assign o_q_push  = acc && i_mode && (r_byte_idx != '0);
    assign o_q_data  = {r_good, r_byte_idx};

    // Next decoder state
    always_comb begin
        n_bit_idx  = r_bit_idx;
        n_byte_idx = r_byte_idx;
        n_awaiting = r_awaiting;
        n_thresh   = r_thresh;
        n_good     = r_good;
        n_byte     = r_byte;
        if (acc) begin
            if (i_mode) begin
                n_bit_idx  = '0;
                n_byte_idx = '0;
                n_awaiting = 1'b1;
                n_thresh   = '0;
                n_good     = 1'b1;
            end else begin
                n_byte_idx = eff_idx;
                if (pass) begin
                    if (r_awaiting) begin
                        n_thresh   = ptbd_pkg::CNT_W'(thr_prod >> ptbd_pkg::DIV5_SHIFT);
                        n_awaiting = 1'b0;
                    end else if (parity_step) begin
                        if (ptbd_pkg::odd_parity(r_byte) != bit_val) begin
                            n_good = 1'b0;
                        end
                        n_bit_idx  = '0;
                        n_byte_idx = eff_idx + 1'b1;
                    end else begin
                        if (r_bit_idx == '0) begin
                            n_byte = '0;
                        end
                        n_byte[r_bit_idx[2:0]] = bit_val;
                        n_bit_idx = r_bit_idx + 1'b1;
                    end
                end
            end
        end
    end

    // Decoder state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_pulse <= ptbd_pkg::RST_MIN_PULSE;
            r_start_min <= ptbd_pkg::RST_START_MIN;
            r_bit_idx   <= '0;
            r_byte_idx  <= '0;
            r_awaiting  <= 1'b1;
            r_thresh    <= '0;
            r_good      <= 1'b1;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    ptbd_pkg::CFG_MIN_PULSE: r_min_pulse <= i_cfg_data;
                    ptbd_pkg::CFG_START_MIN: r_start_min <= i_cfg_data;
                    default: ;
                endcase
            end
            r_bit_idx  <= n_bit_idx;
            r_byte_idx <= n_byte_idx;
            r_awaiting <= n_awaiting;
            r_thresh   <= n_thresh;
            r_good     <= n_good;
        end
    end

    // Word being assembled
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    `PTBD_ASSERT_IMPL(a_no_write_during_drain, i_clk, i_rst_n, o_wr_en, !i_back_busy, "store written while drain pending")
    `PTBD_ASSERT(a_end_clears, i_clk, i_rst_n, acc && i_mode |=> r_awaiting && (r_bit_idx == '0) && (r_byte_idx == '0), "stream end did not clear decoder")

endmodule

>>> sv/ptbd_back.sv
`include "pulse_train_bit_decoder_assert.svh"

module ptbd_back #(
    parameter int MAX_BYTES = ptbd_pkg::MAX_BYTES_DEF,
    parameter int IDX_W     = $clog2(MAX_BYTES),
    parameter int LEN_W     = $clog2(MAX_BYTES + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // drain command queue
    input  logic                           i_q_valid,
    input  logic [LEN_W:0]                 i_q_data,
    output logic                           o_q_pop,
    output logic                           o_busy,
    // byte store read
    output logic                           o_rd_en,
    output logic [IDX_W-1:0]               o_rd_addr,
    input  logic [ptbd_pkg::BYTE_W-1:0]    i_rd_data,
    // result output
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [ptbd_pkg::BYTE_W-1:0]    o_byte_value,
    output logic                           o_last_byte,
    output logic [ptbd_pkg::LEN_OUT_W-1:0] o_message_length,
    output logic                           o_parity_ok
);

    ptbd_pkg::t_back_state r_state;
    ptbd_pkg::t_back_state n_state;
    logic [LEN_W-1:0]      r_ptr;
    logic [LEN_W-1:0]      n_ptr;
    logic [LEN_W-1:0]      r_len;
    logic [LEN_W-1:0]      n_len;
    logic                  r_good;
    logic                  n_good;

    // read stage, data sits in the RAM output register
    logic                  r_s1_v;
    logic                  r_s1_last;
    logic [LEN_W-1:0]      r_s1_len;
    logic                  r_s1_good;

    // output register
    logic                           r_out_v;
    logic [ptbd_pkg::BYTE_W-1:0]    r_out_byte;
    logic                           r_out_last;
    logic [ptbd_pkg::LEN_OUT_W-1:0] r_out_len;
    logic                           r_out_good;

    logic out_free;
    logic s1_move;
    logic last_rd;

    assign out_free = !r_out_v || !i_out_stall;
    assign s1_move  = r_s1_v && out_free;
    assign o_rd_en  = (r_state == ptbd_pkg::BK_DRAIN) && (!r_s1_v || s1_move);
    assign o_rd_addr = r_ptr[IDX_W-1:0];
    assign last_rd  = (r_ptr + 1'b1 == r_len);
    assign o_busy   = i_q_valid || (r_state == ptbd_pkg::BK_DRAIN);

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptbd_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Pop a command, then issue one store read per free slot
    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_len   = r_len;
        n_good  = r_good;
        o_q_pop = 1'b0;
        case (r_state)
            ptbd_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_len   = i_q_data[LEN_W-1:0];
                    n_good  = i_q_data[LEN_W];
                    n_ptr   = '0;
                    n_state = ptbd_pkg::BK_DRAIN;
                end
            end
            ptbd_pkg::BK_DRAIN: begin
                if (o_rd_en) begin
                    n_ptr = r_ptr + 1'b1;
                    if (last_rd) begin
                        n_state = ptbd_pkg::BK_IDLE;
                    end
                end
            end
            default: n_state = ptbd_pkg::BK_IDLE;
        endcase
    end

    // Message bookkeeping
    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_len  <= n_len;
        r_good <= n_good;
    end

    // Advance read stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (o_rd_en) begin
                r_s1_v <= 1'b1;
            end else if (s1_move) begin
                r_s1_v <= 1'b0;
            end
            if (s1_move) begin
                r_out_v <= 1'b1;
            end else if (out_free) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_rd_en) begin
            r_s1_last <= last_rd;
            r_s1_len  <= r_len;
            r_s1_good <= r_good;
        end
        if (s1_move) begin
            r_out_byte <= i_rd_data;
            r_out_last <= r_s1_last;
            r_out_len  <= ptbd_pkg::LEN_OUT_W'(r_s1_len);
            r_out_good <= r_s1_good;
        end
    end

    assign o_out_valid      = r_out_v;
    assign o_byte_value     = r_out_byte;
    assign o_last_byte      = r_out_last;
    assign o_message_length = r_out_len;
    assign o_parity_ok      = r_out_good;

    `PTBD_ASSERT_IMPL(a_pop_when_idle, i_clk, i_rst_n, o_q_pop, r_state == ptbd_pkg::BK_IDLE, "command popped during drain")
    `PTBD_ASSERT_IMPL(a_read_in_range, i_clk, i_rst_n, o_rd_en, r_ptr < r_len, "store read past message end")
    `PTBD_ASSERT(a_stage_moves, i_clk, i_rst_n, s1_move |=> r_out_v, "read data lost on way to output")

endmodule
